// ===== design/wva_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package wva_pkg;

  localparam int COUNT_LIMIT_DEF  = 4094;
  localparam int CORDIC_STEPS_DEF = 16;

  // Field widths
  localparam int ActW  = 2;
  localparam int SpdW  = 16;
  localparam int AngW  = 16;
  localparam int CntW  = 12;
  localparam int SumW  = 40;

  // Action codes
  localparam logic [ActW-1:0] ACT_RECORD = 2'd0;
  localparam logic [ActW-1:0] ACT_READ   = 2'd1;
  localparam logic [ActW-1:0] ACT_CLEAR  = 2'd2;

  // CORDIC gain compensation, 0.6072529350 in Q0.32
  localparam logic [31:0] KINV = 32'd2608131496;

  // atan(2^-i) with 2^32 to a full circle
  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/wva_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface wva_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] speed;
  logic [15:0] direction;

  modport source (output valid, action, speed, direction, input ready);
  modport sink   (input valid, action, speed, direction, output ready);
endinterface

interface wva_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        mean_speed;
  logic [15:0]        mean_direction;
  logic [11:0]        samples;
  logic signed [39:0] sum_x;
  logic signed [39:0] sum_y;

  modport source (output valid, mean_speed, mean_direction, samples, sum_x, sum_y,
                  input ready);
  modport sink   (input valid, mean_speed, mean_direction, samples, sum_x, sum_y,
                  output ready);
endinterface
`default_nettype wire

// ===== design/wva_mulk.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Bit-serial multiply by KINV, one operand bit per cycle while run_i is high, LSB first.
// Once all W operand bits have been shifted through, the product is {hi_o, lo_o}.
module wva_mulk #(
  parameter int W = 16
) (
  input  logic         clk_i,
  input  logic         load_i,
  input  logic [W-1:0] op_i,
  input  logic         run_i,
  output logic [31:0]  hi_o,
  output logic [W-1:0] lo_o
);
  import wva_pkg::*;

  logic [31:0]  p_q;
  logic [W-1:0] l_q;
  logic [32:0]  sum;

  assign sum = {1'b0, p_q} + (l_q[0] ? {1'b0, KINV} : 33'd0);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      p_q <= '0;
      l_q <= op_i;
    end else if (run_i) begin
      p_q <= sum[32:1];
      l_q <= {sum[0], l_q[W-1:1]};
    end
  end

  assign hi_o = p_q;
  assign lo_o = l_q;
endmodule
`default_nettype wire

// ===== design/wind_vector_averager_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Flow: a read item goes straight to the output register; a record item passes through
//   the serial speed*KINV multiply, the rotation CORDIC, accumulate, vectoring setup, the
//   vectoring CORDIC one step a cycle, the serial magnitude scale, the range check and the
//   restoring divider; a zero sum or a saturated mean skips the later steps.
// A new item is taken only after the last is loaded; a full output register holds the core.
// Reset: asynchronous active low; clears accumulators, count, means and handshake.
`default_nettype none
module wind_vector_averager_unit #(
  parameter int COUNT_LIMIT  = wva_pkg::COUNT_LIMIT_DEF,
  parameter int CORDIC_STEPS = wva_pkg::CORDIC_STEPS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wva_in_if.sink    in_i,
  wva_out_if.source out_o
);
  import wva_pkg::*;

  localparam int          XW    = 63;   // CORDIC datapath width
  localparam int          MW    = 62;   // magnitude width
  localparam logic [15:0] LIMIT = 16'(COUNT_LIMIT);
  localparam logic [5:0]  LastStep = 6'(CORDIC_STEPS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RMUL, S_ROT, S_ACC, S_VINIT, S_VEC, S_KMUL, S_MAG, S_NORM, S_DIV, S_DONE
  } state_e;

  state_e state_q;
  logic [5:0] step_q;
  logic       clr_q;
  logic [15:0] dir_q;

  // accumulated state
  logic signed [SumW-1:0] acc_x_q, acc_y_q;
  logic [CntW-1:0]        count_q;
  logic [SpdW-1:0]        avg_spd_q;
  logic [AngW-1:0]        avg_ang_q;

  // CORDIC datapath
  logic signed [XW-1:0] xs_q, ys_q, xs_d, ys_d, dx, dy;
  logic signed [33:0]   zs_q, zs_d, at;
  logic                 ccw, rot_mode;

  logic [MW-1:0]   mag_q;
  logic [CntW-1:0] rem_q;
  logic [15:0]     nq_q;

  // output register
  logic        out_valid_q;
  logic        out_valid_d;
  logic [15:0] o_spd_q, o_ang_q;
  logic [11:0] o_cnt_q;
  logic signed [39:0] o_sx_q, o_sy_q;
  logic        out_load;

  // serial multipliers
  logic [31:0]    m16_hi, m62_hi;
  logic [15:0]    m16_lo;
  logic [MW-1:0]  m62_lo, m62_op;
  logic           last;
  logic           accept;

  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_o.ready);
  // load wins over a handoff in the same cycle; otherwise drop after handoff
  assign out_valid_d = out_load ? 1'b1 :
                       (out_valid_q && out_o.ready) ? 1'b0 : out_valid_q;

  assign out_o.valid          = out_valid_q;
  assign out_o.mean_speed     = o_spd_q;
  assign out_o.mean_direction = o_ang_q;
  assign out_o.samples        = o_cnt_q;
  assign out_o.sum_x          = o_sx_q;
  assign out_o.sum_y          = o_sy_q;

  wva_mulk #(.W(16)) u_mul_spd (
    .clk_i  (clk_i),
    .load_i (accept),
    .op_i   (in_i.speed),
    .run_i  (state_q == S_RMUL),
    .hi_o   (m16_hi),
    .lo_o   (m16_lo)
  );

  wva_mulk #(.W(MW)) u_mul_mag (
    .clk_i  (clk_i),
    .load_i (state_q == S_VEC && last),
    .op_i   (m62_op),
    .run_i  (state_q == S_KMUL),
    .hi_o   (m62_hi),
    .lo_o   (m62_lo)
  );

  // One CORDIC micro-rotation per cycle, shared by rotation and vectoring.
  assign rot_mode = (state_q == S_ROT);
  assign dx = ys_q >>> step_q[4:0];
  assign dy = xs_q >>> step_q[4:0];
  assign at = {2'b00, atan_entry(step_q[4:0])};
  // rotation: turn toward z = 0; vectoring: turn toward y = 0 (y <= 0 goes ccw)
  assign ccw = rot_mode ? !zs_q[33] : (ys_q[XW-1] || (ys_q == '0));

  always_comb begin
    if (ccw) begin
      xs_d = xs_q - dx;
      ys_d = ys_q + dy;
      zs_d = zs_q - at;
    end else begin
      xs_d = xs_q + dx;
      ys_d = ys_q - dy;
      zs_d = zs_q + at;
    end
  end

  // clamp a negative vectoring result to zero before scaling
  assign m62_op = (xs_d[XW-1] || xs_d == '0) ? '0 : xs_d[MW-1:0];

  // the speed product is sampled in the cycle after its sixteenth bit settles
  assign last = (state_q == S_RMUL) ? (step_q == 6'd16) :
                (state_q == S_KMUL) ? (step_q == 6'(MW - 1)) :
                (state_q == S_DIV)  ? (step_q == 6'd15) : (step_q == LastStep);

  // datapath helpers
  logic signed [XW-1:0] rnd_x, rnd_y, vx0, vy0;
  logic signed [SumW-1:0] hx, hy;
  logic [CntW-1:0] hc;
  logic halve, fold;
  logic [MW-1:0] mag_d;
  logic [MW:0]   nsum;
  logic [42:0]   nval;
  logic [12:0]   trial;
  logic [15:0]   z_rnd;

  assign fold  = dir_q[15] ^ dir_q[14];
  assign halve = ({4'b0, count_q} >= LIMIT);
  assign hx    = halve ? (acc_x_q >>> 1) : acc_x_q;
  assign hy    = halve ? (acc_y_q >>> 1) : acc_y_q;
  assign hc    = halve ? (count_q >> 1) : count_q;
  assign rnd_x = (xs_q + XW'(32768)) >>> 16;
  assign rnd_y = (ys_q + XW'(32768)) >>> 16;
  assign vx0   = {{(XW-SumW-20){acc_x_q[SumW-1]}}, acc_x_q, 20'b0};
  assign vy0   = {{(XW-SumW-20){acc_y_q[SumW-1]}}, acc_y_q, 20'b0};
  assign mag_d = {m62_hi, m62_lo[MW-1:32]} + MW'(m62_lo[31]);
  assign nsum  = {1'b0, mag_q} + (MW+1)'({count_q, 19'b0});
  assign nval  = nsum[MW:20];
  assign trial = {rem_q, nq_q[15]};
  assign z_rnd = 16'((zs_q[31:0] + 32'h8000) >> 16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      clr_q       <= 1'b0;
      out_valid_q <= 1'b0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      count_q     <= '0;
      avg_spd_q   <= '0;
      avg_ang_q   <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        S_IDLE: begin
          step_q <= '0;
          if (accept) begin
            dir_q <= in_i.direction;
            clr_q <= (in_i.action == ACT_CLEAR);
            state_q <= (in_i.action == ACT_RECORD) ? S_RMUL : S_DONE;
          end
        end
        S_RMUL: begin
          step_q <= step_q + 6'd1;
          if (last) begin
            // start vector: speed*KINV >> 16, folded into the right half plane
            step_q <= '0;
            xs_q   <= fold ? -XW'(m16_hi) : XW'(m16_hi);
            ys_q   <= '0;
            zs_q   <= 34'(signed'({dir_q[15] ^ fold, dir_q[14:0], 16'b0}));
            state_q <= S_ROT;
          end
        end
        S_ROT, S_VEC: begin
          xs_q <= xs_d;
          ys_q <= ys_d;
          zs_q <= zs_d;
          step_q <= step_q + 6'd1;
          if (last) begin
            step_q  <= '0;
            state_q <= (state_q == S_ROT) ? S_ACC : S_KMUL;
          end
        end
        S_ACC: begin
          acc_x_q <= hx + rnd_x[SumW-1:0];
          acc_y_q <= hy + rnd_y[SumW-1:0];
          count_q <= hc + CntW'(1);
          state_q <= S_VINIT;
        end
        S_VINIT: begin
          if (acc_x_q == '0 && acc_y_q == '0) begin
            avg_spd_q <= '0;
            avg_ang_q <= '0;
            state_q   <= S_DONE;
          end else begin
            // fold the left half plane over, starting at half a circle
            xs_q <= acc_x_q[SumW-1] ? -vx0 : vx0;
            ys_q <= acc_x_q[SumW-1] ? -vy0 : vy0;
            zs_q <= acc_x_q[SumW-1] ? 34'h0_8000_0000 : '0;
            state_q <= S_VEC;
          end
        end
        S_KMUL: begin
          step_q <= step_q + 6'd1;
          if (last) begin
            step_q  <= '0;
            state_q <= S_MAG;
          end
        end
        S_MAG: begin
          mag_q     <= mag_d;
          avg_ang_q <= z_rnd;
          if (count_q == '0) begin
            avg_spd_q <= '0;
            state_q   <= S_DONE;
          end else begin
            state_q <= S_NORM;
          end
        end
        S_NORM: begin
          if (nval >= {15'b0, count_q, 16'b0}) begin
            avg_spd_q <= 16'hFFFF;
            state_q   <= S_DONE;
          end else begin
            rem_q   <= nval[27:16];
            nq_q    <= nval[15:0];
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit a cycle
          if (trial >= {1'b0, count_q}) begin
            rem_q <= 12'(trial - {1'b0, count_q});
            nq_q  <= {nq_q[14:0], 1'b1};
          end else begin
            rem_q <= trial[11:0];
            nq_q  <= {nq_q[14:0], 1'b0};
          end
          step_q <= step_q + 6'd1;
          if (last) begin
            // store the quotient including the bit decided this cycle
            avg_spd_q <= {nq_q[14:0], (trial >= {1'b0, count_q})};
            step_q    <= '0;
            state_q   <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            o_spd_q <= avg_spd_q;
            o_ang_q <= avg_ang_q;
            o_cnt_q <= count_q;
            o_sx_q  <= acc_x_q;
            o_sy_q  <= acc_y_q;
            if (clr_q) begin
              acc_x_q   <= '0;
              acc_y_q   <= '0;
              count_q   <= '0;
              avg_spd_q <= '0;
              avg_ang_q <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // the divider remainder always stays below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < count_q))
    else $error("divider remainder out of range");

  // read-and-clear leaves empty accumulators behind
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && clr_q) |=> (acc_x_q == '0 && acc_y_q == '0 && count_q == '0))
    else $error("clear did not zero the accumulators");

  // a read item skips the compute path
  a_read_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.action != ACT_RECORD) |=> (state_q == S_DONE))
    else $error("read item entered the compute path");

endmodule
`default_nettype wire
